@@ rtl/usb_msc_config_descriptor_parser_defines.svh @@
// Assertion macros for the configuration descriptor parser checker.
// No dependencies; include by bare file name from the checker file.
`ifndef USB_MSC_CONFIG_DESCRIPTOR_PARSER_DEFINES_SVH
`define USB_MSC_CONFIG_DESCRIPTOR_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UCDP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UCDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ucdp_pkg.sv @@
// Shared types and constants for the configuration descriptor parser.
// No dependencies; compile first after the defines header.
package ucdp_pkg;

   // Descriptor and field codes
   localparam logic [7:0] TYPE_INTERFACE = 8'h04;
   localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
   localparam logic [7:0] MSC_CLASS      = 8'h08;
   localparam logic [7:0] MSC_SUBCLASS   = 8'h06;
   localparam logic [7:0] MSC_PROTOCOL   = 8'h50;
   localparam logic [7:0] XFER_MASK      = 8'h03;
   localparam logic [7:0] XFER_BULK      = 8'h02;
   localparam logic [7:0] DIR_IN_BIT     = 8'h80;
   localparam logic [7:0] EP_NUM_MASK    = 8'h0F;

   // Byte offsets within a descriptor
   localparam logic [7:0] OFS_LENGTH   = 8'd0;
   localparam logic [7:0] OFS_TYPE     = 8'd1;
   localparam logic [7:0] OFS_EP_ADDR  = 8'd2;
   localparam logic [7:0] OFS_EP_ATTR  = 8'd3;
   localparam logic [7:0] OFS_CLASS    = 8'd5;
   localparam logic [7:0] OFS_SUBCLASS = 8'd6;
   localparam logic [7:0] OFS_PROTOCOL = 8'd7;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [3:0] in_endpoint;
      logic [3:0] out_endpoint;
   } rsp_type;

   typedef struct packed {
      logic [7:0] byte_offset;
      logic [7:0] desc_length;
      logic [7:0] desc_type;
      logic       class_ok;
      logic       subclass_ok;
      logic [7:0] ep_address_byte;
      logic       msc_seen;
      logic       in_seen;
      logic       out_seen;
      logic [3:0] in_ep_number;
      logic [3:0] out_ep_number;
      logic       halted;
   } parse_state_type;

endpackage

@@ rtl/ucdp_in_stage.sv @@
// Input register stage of the descriptor parser.
// Depends on ucdp_pkg for the request payload type.
module ucdp_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ucdp_pkg::req_type req_payload,
   input  logic             slot_free,
   output logic             advance,
   output ucdp_pkg::req_type item
);
   import ucdp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // A last byte needs a free result slot; any other byte moves on at once.
   assign advance   = valid_ff && (!item_ff.last_byte || slot_free);
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

endmodule

@@ rtl/ucdp_parse_core.sv @@
// Descriptor parsing state and per-byte update logic.
// Depends on ucdp_pkg for codes, offsets and the state type.
module ucdp_parse_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  ucdp_pkg::req_type item,
   output ucdp_pkg::rsp_type result
);
   import ucdp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type parse_nxt;
   logic [7:0]      off_inc;
   logic [7:0]      b;

   assign b       = item.data_byte;
   assign off_inc = state_ff.byte_offset + 8'd1;

   always_comb begin
      parse_nxt = state_ff;
      if (!state_ff.halted) begin
         case (state_ff.byte_offset)
            OFS_LENGTH: begin
               parse_nxt.desc_length = b;
               if (b == 8'd0) begin
                  parse_nxt.halted = 1'b1;
               end
            end
            OFS_TYPE: begin
               parse_nxt.desc_type = b;
            end
            OFS_EP_ADDR: begin
               parse_nxt.ep_address_byte = b;
            end
            OFS_EP_ATTR: begin
               if (state_ff.desc_type == TYPE_ENDPOINT && state_ff.msc_seen &&
                   (b & XFER_MASK) == XFER_BULK) begin
                  if ((state_ff.ep_address_byte & DIR_IN_BIT) != 8'd0) begin
                     parse_nxt.in_ep_number = state_ff.ep_address_byte[3:0];
                     parse_nxt.in_seen      = 1'b1;
                  end else begin
                     parse_nxt.out_ep_number = state_ff.ep_address_byte[3:0];
                     parse_nxt.out_seen      = 1'b1;
                  end
               end
            end
            OFS_CLASS: begin
               parse_nxt.class_ok = (b == MSC_CLASS);
            end
            OFS_SUBCLASS: begin
               parse_nxt.subclass_ok = (b == MSC_SUBCLASS);
            end
            OFS_PROTOCOL: begin
               if (state_ff.desc_type == TYPE_INTERFACE && state_ff.class_ok &&
                   state_ff.subclass_ok && b == MSC_PROTOCOL) begin
                  parse_nxt.msc_seen = 1'b1;
               end
            end
            default: begin
            end
         endcase
         // Wrap to the next descriptor once the length is used up.
         if (!parse_nxt.halted) begin
            parse_nxt.byte_offset = (off_inc >= parse_nxt.desc_length) ? 8'd0 : off_inc;
         end
      end
   end

   always_comb begin
      result.status = (parse_nxt.msc_seen && parse_nxt.in_seen && parse_nxt.out_seen)
                      ? STATUS_OK : STATUS_UNSUPPORTED;
      result.in_endpoint  = parse_nxt.in_ep_number & EP_NUM_MASK[3:0];
      result.out_endpoint = parse_nxt.out_ep_number & EP_NUM_MASK[3:0];
   end

   // Clear everything after the last byte of a set.
   assign state_in = item.last_byte ? '0 : parse_nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/ucdp_out_stage.sv @@
// Result register stage of the descriptor parser.
// Depends on ucdp_pkg for the response payload type.
module ucdp_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ucdp_pkg::rsp_type result,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ucdp_pkg::rsp_type rsp_payload
);
   import ucdp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign slot_free   = !valid_ff || rsp_ready;
   assign valid_in    = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= result;
      end
   end

endmodule

@@ rtl/usb_msc_config_descriptor_parser.sv @@
// USB mass-storage configuration descriptor parser, top level.
// Path: a transferred byte is held in the input register, then parsed into the parse state;
// a last byte also loads its result into the result register, which drives rsp_valid.
// Throughput: one byte per cycle; only a held result stalls a last byte in the input stage.
// Reset: synchronous, active high; clears both valid flags and all parse state.
// Depends on ucdp_pkg, ucdp_in_stage, ucdp_parse_core and ucdp_out_stage.
module usb_msc_config_descriptor_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ucdp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ucdp_pkg::rsp_type rsp_payload
);
   import ucdp_pkg::*;

   logic    slot_free;   // result register can take a new result this cycle
   logic    advance;     // held byte moves into the parser this cycle
   req_type item;        // byte waiting in the input register
   rsp_type result;      // result as it stands after the held byte

   // Hold each transferred byte for one parse step.
   ucdp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .slot_free   (slot_free),
      .advance     (advance),
      .item        (item)
   );

   // Advance the descriptor walk by one byte; clear state after the last byte.
   ucdp_parse_core u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .take   (advance),
      .item   (item),
      .result (result)
   );

   // Hold the result until the result transfer completes.
   ucdp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && item.last_byte),
      .result      (result),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/ucdp_checker.sv @@
// Port-level checker for the descriptor parser, bound to the top level.
// Depends on ucdp_pkg and usb_msc_config_descriptor_parser_defines.svh.
`include "usb_msc_config_descriptor_parser_defines.svh"

module ucdp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ucdp_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ucdp_pkg::rsp_type rsp_payload
);
   import ucdp_pkg::*;

   `UCDP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result dropped or changed while stalled")
   `UCDP_ASSERT_NOW(a_ready_only_on_stall, !req_ready, rsp_valid && !rsp_ready, "input stalled while result side is free")
   `UCDP_ASSERT_NOW(a_idle_after_reset, $past(reset), !rsp_valid, "result valid right after reset")
   `UCDP_ASSERT_NEXT(a_req_hold_seen, req_valid && !req_ready, req_valid && $stable(req_payload.last_byte), "request withdrawn while stalled")

endmodule

bind usb_msc_config_descriptor_parser ucdp_checker u_ucdp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
